FILE: design/sorted_set_insert_erase_find_top_defines.svh
// assertion macros for the sorted set block
`ifndef SORTED_SET_INSERT_ERASE_FIND_TOP_DEFINES_SVH
`define SORTED_SET_INSERT_ERASE_FIND_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define SSIF_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("ssif assertion failed");
`define SSIF_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("ssif assertion failed");
`else
`define SSIF_ASSERT(lbl, clk, rstn, prop)
`define SSIF_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

FILE: design/ssif_pkg.sv
// shared types and constants for the sorted set block
package ssif_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned KEY_W    = 32;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_ERASE  = 2'd1,
    KIND_FIND   = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_ERASE,
    OP_CLEAR
  } op_e;

  typedef struct packed {
    op_e                      op;
    logic signed [KEY_W-1:0]  value;
  } cell_ctrl_t;

endpackage

FILE: design/ssif_cell.sv
// one slot of the ordered store: compare against the request and shift
module ssif_cell
  import ssif_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cell_ctrl_t               ctrl_i,
  input  logic signed [KEY_W-1:0]  left_key_i,
  input  logic                     left_occ_i,
  input  logic                     left_lt_i,
  input  logic signed [KEY_W-1:0]  right_key_i,
  input  logic                     right_occ_i,
  output logic signed [KEY_W-1:0]  key_o,
  output logic                     occ_o,
  output logic                     lt_o,
  output logic                     eq_o
);

  logic signed [KEY_W-1:0] key_q, key_d;
  logic                    occ_q, occ_d;

  assign lt_o  = occ_q && (key_q < ctrl_i.value);
  assign eq_o  = occ_q && (key_q == ctrl_i.value);
  assign key_o = key_q;
  assign occ_o = occ_q;

  always_comb begin
    key_d = key_q;
    occ_d = occ_q;
    unique case (ctrl_i.op)
      OP_HOLD: ;
      OP_INSERT: begin
        if (!lt_o) begin
          // first slot not below the value takes it, the rest move up
          if (left_lt_i) begin
            key_d = ctrl_i.value;
            occ_d = 1'b1;
          end else begin
            key_d = left_key_i;
            occ_d = left_occ_i;
          end
        end
      end
      OP_ERASE: begin
        if (!lt_o) begin
          key_d = right_key_i;
          occ_d = right_occ_i;
        end
      end
      OP_CLEAR: occ_d = 1'b0;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

endmodule

FILE: design/sorted_set_insert_erase_find_top.sv
// sorted set of signed keys held in a row of compare-and-shift slots
// result is valid in the cycle after the request beat is accepted
// throughput: one request per cycle while no result is stalled, set by the slot shift
// a request is held off only while an earlier result is stalled at the output
// reset empties every slot and clears the count at once; no sweep is needed
`include "sorted_set_insert_erase_find_top_defines.svh"

module sorted_set_insert_erase_find_top
  import ssif_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         kind_i,
  input  logic signed [31:0] value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               was_present_o,
  output logic               dropped_full_o,
  output logic [4:0]         entry_count_o
);

  logic signed [KEY_W-1:0] key_w [CAPACITY];
  logic [CAPACITY-1:0]     occ_w, lt_w, eq_w;

  cell_ctrl_t ctrl;
  logic       in_acc;
  logic       present;
  logic       full;
  logic       dropped;
  kind_e      kind;

  logic [CNT_W-1:0] count_q, count_d;
  logic             out_valid_q;
  logic             was_present_q, dropped_full_q;
  logic [4:0]       entry_count_q;

  assign kind       = kind_e'(kind_i);
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign present    = |eq_w;
  assign full       = (count_q == CNT_W'(CAPACITY));
  assign dropped    = (kind == KIND_INSERT) && !present && full;

  always_comb begin
    ctrl.value = value_i;
    ctrl.op    = OP_HOLD;
    count_d    = count_q;
    if (in_acc) begin
      unique case (kind)
        KIND_INSERT: begin
          if (!present && !full) begin
            ctrl.op = OP_INSERT;
            count_d = count_q + CNT_W'(1);
          end
        end
        KIND_ERASE: begin
          if (present) begin
            ctrl.op = OP_ERASE;
            count_d = count_q - CNT_W'(1);
          end
        end
        KIND_FIND: ;
        KIND_CLEAR: begin
          ctrl.op = OP_CLEAR;
          count_d = '0;
        end
        default: ;
      endcase
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [KEY_W-1:0] left_key, right_key;
    logic                    left_occ, left_lt, right_occ;

    if (g == 0) begin : g_head
      assign left_key = '0;
      assign left_occ = 1'b0;
      assign left_lt  = 1'b1;
    end else begin : g_mid
      assign left_key = key_w[g-1];
      assign left_occ = occ_w[g-1];
      assign left_lt  = lt_w[g-1];
    end

    if (g == CAPACITY - 1) begin : g_tail
      assign right_key = '0;
      assign right_occ = 1'b0;
    end else begin : g_body
      assign right_key = key_w[g+1];
      assign right_occ = occ_w[g+1];
    end

    ssif_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .left_key_i  (left_key),
      .left_occ_i  (left_occ),
      .left_lt_i   (left_lt),
      .right_key_i (right_key),
      .right_occ_i (right_occ),
      .key_o       (key_w[g]),
      .occ_o       (occ_w[g]),
      .lt_o        (lt_w[g]),
      .eq_o        (eq_w[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (in_acc) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      was_present_q  <= (kind != KIND_CLEAR) && present;
      dropped_full_q <= dropped;
      entry_count_q  <= 5'(count_d);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign was_present_o  = was_present_q;
  assign dropped_full_o = dropped_full_q;
  assign entry_count_o  = entry_count_q;

  `SSIF_ASSERT_ALWAYS(a_count_bound, clk_i, count_q <= CNT_W'(CAPACITY))
  `SSIF_ASSERT(a_occ_matches_count, clk_i, rst_ni, $countones(occ_w) == 32'(count_q))
  `SSIF_ASSERT(a_clear_empties, clk_i, rst_ni,
               (in_acc && kind == KIND_CLEAR) |=> (count_q == '0 && occ_w == '0))
  `SSIF_ASSERT(a_drop_keeps_count, clk_i, rst_ni, (in_acc && dropped) |=> $stable(count_q))

endmodule
